// ----- rtl/core/lom_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lom_pkg: shared types and constants for the limit order matcher
// Payload structs, heap geometry, sequencer states.
// ---------------------------------------------------------------------------
package lom_pkg;

  localparam int unsigned HEAP_DEPTH = 1024;
  localparam int unsigned IDX_W      = $clog2(HEAP_DEPTH);
  localparam int unsigned CNT_W      = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned SUM_W      = 41;
  localparam logic [29:0] BACKLOG_MOD = 30'd1000000007;

  typedef struct packed {
    logic [29:0] order_price;
    logic [29:0] order_amount;
    logic        order_side;
  } order_t;

  typedef struct packed {
    logic [29:0] backlog_total_mod;
    logic [29:0] rested_amount;
    logic        book_full;
  } result_t;

  typedef struct packed {
    logic [29:0] price;
    logic [29:0] amount;
  } entry_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_TOP_RD,
    ST_TOP_WT,
    ST_MATCH,
    ST_LAST_RD,
    ST_LAST_WT,
    ST_DN_L_RD,
    ST_DN_L_WT,
    ST_DN_R_RD,
    ST_DN_R_WT,
    ST_DN_SWAP,
    ST_INSERT,
    ST_UP_RD,
    ST_UP_WT,
    ST_UP_SWAP,
    ST_MOD,
    ST_OUT
  } state_t;

endpackage

// ----- rtl/core/lom_heap_ram.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lom_heap_ram: single port heap storage
// One read or one write per cycle, registered read data.
// ---------------------------------------------------------------------------
module lom_heap_ram (
  input  logic                      clk,
  input  logic                      we,
  input  logic [lom_pkg::IDX_W-1:0] addr,
  input  lom_pkg::entry_t           wdata,
  output lom_pkg::entry_t           rdata
);

  lom_pkg::entry_t mem [lom_pkg::HEAP_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- rtl/core/limit_order_matcher_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// limit_order_matcher_top: limit order book with one order per transaction
// Max-heap of buys, min-heap of sells, walked by a single sequencer.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one order per transaction (price, amount, side).
//   out_* : one result per order (backlog mod 1e9+7, rested amount, full).
//   Orders are processed one at a time; in_ready is high only in the idle
//   state, so it is low for the whole time an order is in work. A finished
//   result sits in the output register, and the next order may be taken
//   while it waits there.
//   Steps: accept, then per look at the opposite top a read, a wait and a
//   match; a fetch of the last entry when a top empties; per heap level
//   on sift down two child reads and a swap, and per level on sift up a
//   parent read, a wait and a swap; plus insert, the modulo and posting
//   the result. The single memory port per heap sets the pace.
//   The modulo is 12 conditional subtracts of a shifted modulus: one
//   41-bit compare and subtract per cycle after a load of the running sum.
//   Reset clears the counts and the running sum; heap contents are not
//   cleared, only entries below the count are ever read.
//   A stalled receiver holds the result in the output register; the next
//   order's result waits in the last state until that one is delivered.
// ---------------------------------------------------------------------------
module limit_order_matcher_top (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  lom_pkg::order_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output lom_pkg::result_t out_data
);

  localparam int unsigned IW = lom_pkg::IDX_W;
  localparam int unsigned CW = lom_pkg::CNT_W;
  localparam int unsigned SW = lom_pkg::SUM_W;
  localparam logic [SW-1:0] BACKLOG_MOD_EXT = SW'(lom_pkg::BACKLOG_MOD);

  lom_pkg::state_t state_r, state_nxt;

  logic [CW-1:0] buy_cnt_r, buy_cnt_nxt, sell_cnt_r, sell_cnt_nxt;
  logic [SW-1:0] sum_r, sum_nxt;
  logic [29:0]   price_r, price_nxt, amt_r, amt_nxt;
  logic          side_r, side_nxt;
  logic [IW-1:0] pos_r, pos_nxt, best_r, best_nxt;
  lom_pkg::entry_t cur_r, cur_nxt, bent_r, bent_nxt;
  logic [SW-1:0] rem_r, rem_nxt;
  logic [3:0]    mstep_r, mstep_nxt;
  lom_pkg::result_t res_r, res_nxt;
  logic          full_r, full_nxt, rested_flag_r, rested_flag_nxt;
  logic          out_valid_r;

  // memory ports
  logic            buy_we, sell_we;
  logic [IW-1:0]   mem_addr;
  lom_pkg::entry_t mem_wdata, buy_rd, sell_rd, rd;

  lom_heap_ram u_buy (.clk(clk), .we(buy_we), .addr(mem_addr),
                      .wdata(mem_wdata), .rdata(buy_rd));
  lom_heap_ram u_sell (.clk(clk), .we(sell_we), .addr(mem_addr),
                       .wdata(mem_wdata), .rdata(sell_rd));

  // side_r selects: opposite heap during matching, own heap on insert
  logic use_sell;  // heap in use is the sell heap
  logic mem_we;
  logic in_match_phase;
  assign rd = use_sell ? sell_rd : buy_rd;
  assign buy_we  = mem_we & ~use_sell;
  assign sell_we = mem_we &  use_sell;

  // heap ordering: true when a ranks above b in the heap in use
  function automatic logic ranks(input logic [29:0] a, input logic [29:0] b,
                                 input logic maxfirst);
    ranks = maxfirst ? (a > b) : (a < b);
  endfunction

  logic [CW-1:0] opp_cnt, own_cnt;
  assign opp_cnt = side_r ? buy_cnt_r : sell_cnt_r;
  assign own_cnt = side_r ? sell_cnt_r : buy_cnt_r;

  logic [29:0] deal;
  logic [CW:0] lidx, ridx;
  logic [SW-1:0] shifted_mod;

  always_comb begin
    state_nxt = state_r;
    buy_cnt_nxt = buy_cnt_r;  sell_cnt_nxt = sell_cnt_r;
    sum_nxt = sum_r;  price_nxt = price_r;  amt_nxt = amt_r;  side_nxt = side_r;
    pos_nxt = pos_r;  best_nxt = best_r;  cur_nxt = cur_r;  bent_nxt = bent_r;
    rem_nxt = rem_r;  mstep_nxt = mstep_r;  res_nxt = res_r;
    full_nxt = full_r;  rested_flag_nxt = rested_flag_r;
    mem_we = 1'b0;  mem_addr = pos_r;  mem_wdata = cur_r;
    in_match_phase = 1'b1;
    deal = (amt_r < cur_r.amount) ? amt_r : cur_r.amount;
    lidx = {1'b0, pos_r, 1'b1};
    ridx = {1'b0, pos_r, 1'b0} + (CW+1)'(2);
    // steps 1..12 subtract the modulus shifted by 11..0
    shifted_mod = BACKLOG_MOD_EXT << (4'd12 - mstep_r);
    in_ready = 1'b0;

    unique case (state_r)
      lom_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          price_nxt = in_data.order_price;
          amt_nxt   = in_data.order_amount;
          side_nxt  = in_data.order_side;
          full_nxt  = 1'b0;
          rested_flag_nxt = 1'b0;
          state_nxt = lom_pkg::ST_TOP_RD;
        end
      end
      lom_pkg::ST_TOP_RD: begin
        pos_nxt = '0;
        mem_addr = '0;
        if (amt_r == '0) begin
          state_nxt = lom_pkg::ST_MOD;
        end else if (opp_cnt == '0) begin
          state_nxt = lom_pkg::ST_INSERT;
        end else begin
          state_nxt = lom_pkg::ST_TOP_WT;
        end
      end
      lom_pkg::ST_TOP_WT: begin
        mem_addr = '0;
        cur_nxt = rd;
        state_nxt = lom_pkg::ST_MATCH;
      end
      lom_pkg::ST_MATCH: begin
        if (side_r ? (cur_r.price >= price_r) : (cur_r.price <= price_r)) begin
          amt_nxt = amt_r - deal;
          sum_nxt = sum_r - SW'(deal);
          cur_nxt.amount = cur_r.amount - deal;
          if (cur_r.amount == deal) begin
            // top emptied: fetch last entry
            if (side_r) buy_cnt_nxt = buy_cnt_r - CW'(1);
            else        sell_cnt_nxt = sell_cnt_r - CW'(1);
            state_nxt = lom_pkg::ST_LAST_RD;
          end else begin
            mem_we = 1'b1;
            mem_addr = '0;
            mem_wdata = cur_nxt;
            state_nxt = lom_pkg::ST_TOP_RD;
          end
        end else begin
          state_nxt = lom_pkg::ST_INSERT;
        end
      end
      lom_pkg::ST_LAST_RD: begin
        mem_addr = IW'(opp_cnt);
        if (opp_cnt == '0) state_nxt = lom_pkg::ST_TOP_RD;
        else               state_nxt = lom_pkg::ST_LAST_WT;
      end
      lom_pkg::ST_LAST_WT: begin
        mem_addr = IW'(opp_cnt);
        cur_nxt = rd;
        pos_nxt = '0;
        best_nxt = '0;
        state_nxt = lom_pkg::ST_DN_L_RD;
      end
      lom_pkg::ST_DN_L_RD: begin
        best_nxt = pos_r;
        bent_nxt = cur_r;
        if (lidx < (CW+1)'(opp_cnt)) begin
          mem_addr = IW'(lidx);
          state_nxt = lom_pkg::ST_DN_L_WT;
        end else begin
          state_nxt = lom_pkg::ST_DN_SWAP;
        end
      end
      lom_pkg::ST_DN_L_WT: begin
        if (ranks(rd.price, bent_r.price, side_r)) begin
          best_nxt = IW'(lidx);
          bent_nxt = rd;
        end
        state_nxt = lom_pkg::ST_DN_R_RD;
      end
      lom_pkg::ST_DN_R_RD: begin
        if (ridx < (CW+1)'(opp_cnt)) begin
          mem_addr = IW'(ridx);
          state_nxt = lom_pkg::ST_DN_R_WT;
        end else begin
          state_nxt = lom_pkg::ST_DN_SWAP;
        end
      end
      lom_pkg::ST_DN_R_WT: begin
        if (ranks(rd.price, bent_r.price, side_r)) begin
          best_nxt = IW'(ridx);
          bent_nxt = rd;
        end
        state_nxt = lom_pkg::ST_DN_SWAP;
      end
      lom_pkg::ST_DN_SWAP: begin
        // write the winner at pos; the moving entry descends into best
        mem_we = 1'b1;
        mem_addr = pos_r;
        if (best_r == pos_r) begin
          mem_wdata = cur_r;
          state_nxt = lom_pkg::ST_TOP_RD;
        end else begin
          mem_wdata = bent_r;
          pos_nxt = best_r;
          state_nxt = lom_pkg::ST_DN_L_RD;
        end
      end
      lom_pkg::ST_INSERT: begin
        in_match_phase = 1'b0;
        if (own_cnt >= CW'(lom_pkg::HEAP_DEPTH)) begin
          full_nxt = 1'b1;
          state_nxt = lom_pkg::ST_MOD;
        end else begin
          cur_nxt.price = price_r;
          cur_nxt.amount = amt_r;
          pos_nxt = IW'(own_cnt);
          if (side_r) sell_cnt_nxt = sell_cnt_r + CW'(1);
          else        buy_cnt_nxt = buy_cnt_r + CW'(1);
          sum_nxt = sum_r + SW'(amt_r);
          rested_flag_nxt = 1'b1;
          state_nxt = lom_pkg::ST_UP_RD;
        end
      end
      lom_pkg::ST_UP_RD: begin
        in_match_phase = 1'b0;
        mem_addr = (pos_r - IW'(1)) >> 1;
        if (pos_r == '0) begin
          mem_we = 1'b1;
          mem_addr = '0;
          mem_wdata = cur_r;
          state_nxt = lom_pkg::ST_MOD;
        end else begin
          state_nxt = lom_pkg::ST_UP_WT;
        end
      end
      lom_pkg::ST_UP_WT: begin
        in_match_phase = 1'b0;
        mem_addr = (pos_r - IW'(1)) >> 1;
        bent_nxt = rd;
        state_nxt = lom_pkg::ST_UP_SWAP;
      end
      lom_pkg::ST_UP_SWAP: begin
        in_match_phase = 1'b0;
        mem_we = 1'b1;
        mem_addr = pos_r;
        if (ranks(cur_r.price, bent_r.price, !side_r)) begin
          mem_wdata = bent_r;
          pos_nxt = (pos_r - IW'(1)) >> 1;
          state_nxt = lom_pkg::ST_UP_RD;
        end else begin
          mem_wdata = cur_r;
          state_nxt = lom_pkg::ST_MOD;
        end
      end
      lom_pkg::ST_MOD: begin
        // restoring reduction, one shifted modulus per cycle
        in_match_phase = 1'b0;
        if (mstep_r == 4'd0) begin
          rem_nxt = sum_r;
          mstep_nxt = 4'd1;
        end else begin
          if (rem_r >= shifted_mod) rem_nxt = rem_r - shifted_mod;
          if (mstep_r == 4'd12) begin
            mstep_nxt = 4'd0;
            state_nxt = lom_pkg::ST_OUT;
          end else begin
            mstep_nxt = mstep_r + 4'd1;
          end
        end
      end
      lom_pkg::ST_OUT: begin
        in_match_phase = 1'b0;
        res_nxt.backlog_total_mod = rem_r[29:0];
        res_nxt.rested_amount = rested_flag_r ? amt_r : 30'd0;
        res_nxt.book_full = full_r;
        if (!out_valid_r) state_nxt = lom_pkg::ST_IDLE;
      end
      default: state_nxt = lom_pkg::ST_IDLE;
    endcase
  end

  assign use_sell = in_match_phase ? ~side_r : side_r;

  assign out_valid = out_valid_r;
  assign out_data  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lom_pkg::ST_IDLE;
      buy_cnt_r <= '0;
      sell_cnt_r <= '0;
      sum_r <= '0;
      mstep_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      buy_cnt_r <= buy_cnt_nxt;
      sell_cnt_r <= sell_cnt_nxt;
      sum_r <= sum_nxt;
      mstep_r <= mstep_nxt;
      if (state_r == lom_pkg::ST_OUT && !out_valid_r) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
    price_r <= price_nxt;  amt_r <= amt_nxt;  side_r <= side_nxt;
    pos_r <= pos_nxt;  best_r <= best_nxt;  cur_r <= cur_nxt;  bent_r <= bent_nxt;
    rem_r <= rem_nxt;  full_r <= full_nxt;  rested_flag_r <= rested_flag_nxt;
    if (state_r == lom_pkg::ST_OUT && !out_valid_r) res_r <= res_nxt;
  end

  // assertions
  a_cnt_buy: assert property (@(posedge clk) disable iff (!rst_n)
    buy_cnt_r <= CW'(lom_pkg::HEAP_DEPTH)) else $error("buy count overflow");
  a_cnt_sell: assert property (@(posedge clk) disable iff (!rst_n)
    sell_cnt_r <= CW'(lom_pkg::HEAP_DEPTH)) else $error("sell count overflow");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(res_r)))
    else $error("result dropped or changed while stalled");
  a_res_mod: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (res_r.backlog_total_mod < lom_pkg::BACKLOG_MOD))
    else $error("backlog not reduced");

endmodule

// ----- sim/tb_limit_order_matcher_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_limit_order_matcher_top: self-checking bench for the limit order matcher
// Feeds orders through the valid/ready input, predicts each result from a
// private copy of both heaps and the resting sum, and compares every result
// field by field. Random idle bursts on both sides, none near the end.
// ---------------------------------------------------------------------------
module tb_limit_order_matcher_top;

  localparam int unsigned BUY  = 0;
  localparam int unsigned SELL = 1;
  localparam logic [29:0] MAX30 = 30'h3FFF_FFFF;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  lom_pkg::order_t  in_data;
  logic             out_valid;
  logic             out_ready;
  lom_pkg::result_t out_data;

  limit_order_matcher_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Book mirror: index 0 is the buy max-heap, index 1 the sell min-heap
  logic [29:0]     book_price [2][lom_pkg::HEAP_DEPTH];
  logic [29:0]     book_amt   [2][lom_pkg::HEAP_DEPTH];
  int unsigned     book_cnt   [2];
  longint unsigned resting_sum;

  lom_pkg::order_t  pending_orders[$];
  lom_pkg::result_t expected_results[$];
  int      errors;
  int      orders_sent;
  int      results_seen;
  int      trades_seen;
  int      full_seen;
  int      in_gap;
  int      out_stall;
  bit      quiet;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic bit ranks_higher(int unsigned s, logic [29:0] a, logic [29:0] b);
    return (s == BUY) ? (a > b) : (a < b);
  endfunction

  function automatic void swap_entries(int unsigned s, int unsigned a, int unsigned b);
    logic [29:0] tp;
    logic [29:0] ta;
    tp = book_price[s][a];
    ta = book_amt[s][a];
    book_price[s][a] = book_price[s][b];
    book_amt[s][a]   = book_amt[s][b];
    book_price[s][b] = tp;
    book_amt[s][b]   = ta;
  endfunction

  // Work out the result of one order and update the mirror book
  function automatic lom_pkg::result_t match_order(lom_pkg::order_t o);
    lom_pkg::result_t r;
    int unsigned own;
    int unsigned opp;
    logic [29:0] amt;
    logic [29:0] deal;
    int unsigned pos;
    int unsigned best;
    int unsigned par;
    bit          crosses;
    own = o.order_side ? SELL : BUY;
    opp = o.order_side ? BUY : SELL;
    amt = o.order_amount;
    r   = '0;
    while (amt > 0 && book_cnt[opp] > 0) begin
      crosses = o.order_side ? (book_price[opp][0] >= o.order_price)
                             : (book_price[opp][0] <= o.order_price);
      if (!crosses) break;
      deal = (amt < book_amt[opp][0]) ? amt : book_amt[opp][0];
      amt -= deal;
      book_amt[opp][0] -= deal;
      resting_sum -= deal;
      trades_seen++;
      if (book_amt[opp][0] == 0) begin
        book_cnt[opp]--;
        book_price[opp][0] = book_price[opp][book_cnt[opp]];
        book_amt[opp][0]   = book_amt[opp][book_cnt[opp]];
        pos = 0;
        // sift the moved entry down; strict compares keep equal prices put
        forever begin
          best = pos;
          if (2*pos+1 < book_cnt[opp] &&
              ranks_higher(opp, book_price[opp][2*pos+1], book_price[opp][best]))
            best = 2*pos+1;
          if (2*pos+2 < book_cnt[opp] &&
              ranks_higher(opp, book_price[opp][2*pos+2], book_price[opp][best]))
            best = 2*pos+2;
          if (best == pos) break;
          swap_entries(opp, pos, best);
          pos = best;
        end
      end
    end
    if (amt > 0) begin
      if (book_cnt[own] >= lom_pkg::HEAP_DEPTH) begin
        r.book_full = 1'b1;
        full_seen++;
      end else begin
        pos = book_cnt[own];
        book_price[own][pos] = o.order_price;
        book_amt[own][pos]   = amt;
        book_cnt[own]++;
        while (pos > 0) begin
          par = (pos - 1) / 2;
          if (!ranks_higher(own, book_price[own][pos], book_price[own][par])) break;
          swap_entries(own, pos, par);
          pos = par;
        end
        resting_sum += amt;
        r.rested_amount = amt;
      end
    end
    r.backlog_total_mod = 30'(resting_sum % 64'd1000000007);
    return r;
  endfunction

  function automatic void queue_order(logic [29:0] p, logic [29:0] a, logic s);
    lom_pkg::order_t o;
    o.order_price  = p;
    o.order_amount = a;
    o.order_side   = s;
    pending_orders.push_back(o);
  endfunction

  // Driver: a new transaction only once the previous one was taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      in_gap   <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        expected_results.push_back(match_order(in_data));
        orders_sent++;
      end
      if (in_gap > 0) begin
        in_gap   <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_orders.size() > 0) begin
        in_data  <= pending_orders.pop_front();
        in_valid <= 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0) in_gap <= $urandom_range(1, 8);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each delivered result, stalls the receiver in bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_stall <= 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result with none expected: %p", out_data);
          errors++;
        end else begin
          lom_pkg::result_t e;
          e = expected_results.pop_front();
          if (out_data.backlog_total_mod !== e.backlog_total_mod) begin
            $error("backlog_total_mod: expected %0d, got %0d",
                   e.backlog_total_mod, out_data.backlog_total_mod);
            errors++;
          end
          if (out_data.rested_amount !== e.rested_amount) begin
            $error("rested_amount: expected %0d, got %0d",
                   e.rested_amount, out_data.rested_amount);
            errors++;
          end
          if (out_data.book_full !== e.book_full) begin
            $error("book_full: expected %0d, got %0d", e.book_full, out_data.book_full);
            errors++;
          end
        end
      end
      if (out_stall > 0) begin
        out_stall <= out_stall - 1;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
        out_stall <= $urandom_range(0, 7);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Idle bursts stop for the last stretch of orders
  always @(posedge clk) quiet <= (pending_orders.size() < 150);

  initial begin
    #100_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    logic [29:0] p;
    errors = 0; orders_sent = 0; results_seen = 0; trades_seen = 0; full_seen = 0;
    resting_sum = 0; book_cnt[BUY] = 0; book_cnt[SELL] = 0; quiet = 1'b0;
    rst_n = 1'b0; in_valid = 1'b0; in_data = '0; out_ready = 1'b0;

    // Directed: zero amounts, field extremes, full cross, equal prices
    queue_order(30'd500, 30'd0, 1'b0);
    queue_order(30'd500, 30'd0, 1'b1);
    queue_order(MAX30, MAX30, 1'b0);
    queue_order(30'd0, MAX30, 1'b1);
    queue_order(30'd0, MAX30, 1'b0);
    queue_order(MAX30, 30'd5, 1'b1);
    queue_order(MAX30, MAX30, 1'b1);
    queue_order(MAX30, 30'd1, 1'b0);
    for (int i = 0; i < 5; i++) queue_order(30'd100, 30'(10 + i), 1'b0);
    queue_order(30'd100, 30'd25, 1'b1);
    queue_order(30'd101, 30'd7, 1'b1);
    queue_order(30'd101, 30'd30, 1'b0);
    queue_order(30'd100, 30'd0, 1'b1);
    queue_order(30'd99, MAX30, 1'b1);

    // Random mixed book around a price band, with some wide-open orders
    for (int i = 0; i < 700; i++) begin
      case ($urandom_range(0, 9))
        0: queue_order(30'($urandom), 30'($urandom), 1'($urandom));
        1: queue_order(30'($urandom_range(900, 1300)), 30'd0, 1'($urandom));
        default: begin
          if ($urandom_range(0, 1)) queue_order(30'($urandom_range(1000, 1200)),
                                                30'($urandom_range(1, 1000)), 1'b1);
          else queue_order(30'($urandom_range(900, 1100)),
                           30'($urandom_range(1, 1000)), 1'b0);
        end
      endcase
    end

    // Low buys that rarely cross: fill the buy heap past capacity
    for (int i = 0; i < 1060; i++) begin
      p = 30'($urandom_range(0, 500));
      queue_order(p, ($urandom_range(0, 7) == 0) ? 30'($urandom) :
                     30'($urandom_range(1, 2000)), 1'b0);
    end

    // Sells into the full book: partial fills, with a few deep sweeps among them
    for (int i = 0; i < 260; i++) begin
      if (i % 60 == 59) queue_order(30'd0, MAX30, 1'b1);
      else queue_order(30'($urandom_range(0, 600)), 30'($urandom_range(1, 5000)), 1'b1);
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_orders.size() == 0 && !in_valid && expected_results.size() == 0);
    repeat (300) @(posedge clk);
    $display("%0d orders, %0d results, %0d trades, %0d orders dropped on a full book",
             orders_sent, results_seen, trades_seen, full_seen);
    $display("final book: %0d buys, %0d sells resting", book_cnt[BUY], book_cnt[SELL]);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
